/* design/mct_pkg.sv */
// shared types, byte constants and character class functions for the script tokenizer
package mct_pkg;

	localparam int MAX_RESULTS = 3;
	localparam int CNT_W       = 2;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_BANG      = 8'h21;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_AMP       = 8'h26;
	localparam logic [7:0] CH_QUEST     = 8'h3F;
	localparam logic [7:0] CH_UNDER     = 8'h5F;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;

	localparam logic [1:0] ROLE_TEXT   = 2'd0;
	localparam logic [1:0] ROLE_NAME   = 2'd1;
	localparam logic [1:0] ROLE_OPTION = 2'd2;
	localparam logic [1:0] ROLE_END    = 2'd3;

	typedef enum logic [1:0] {
		MODE_TEXT   = 2'd0,
		MODE_HELD   = 2'd1,
		MODE_NAME   = 2'd2,
		MODE_OPTION = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  held_pct;
		logic  trail;
		logic  esc;
		logic  in_text;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		mode:     MODE_TEXT,
		held_pct: 1'b0,
		trail:    1'b0,
		esc:      1'b0,
		in_text:  1'b0
	};

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] role;
		logic       part_start;
		logic       unterminated;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic    [CNT_W-1:0]       count;
	} bundle_t;

	function automatic logic is_marker(input logic [7:0] b);
		return (b == CH_BACKSLASH) || (b == CH_PERCENT);
	endfunction

	function automatic logic is_lead(input logic [7:0] b, input logic en);
		return en && (((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC)));
	endfunction

	function automatic logic is_name_char(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) ||
		       ((b >= 8'h61) && (b <= 8'h7A)) ||
		       ((b >= 8'h30) && (b <= 8'h39)) ||
		       (b == CH_BANG) || (b == CH_STAR) || (b == CH_AMP) ||
		       (b == CH_QUEST) || (b == CH_UNDER);
	endfunction

endpackage

/* design/markup_command_tokenizer_unit.sv */
// top level of the markup script tokenizer: input register, scan state and result queue
//
//  channel   signals                                   direction  meaning
//  in        in_valid in_stall in_byte end_of_script   request in one script byte
//  out       out_valid out_stall out_byte role ...     request out one tagged byte
//  cfg       cfg_we cfg_wdata                          write in   double_byte_enable
//
// a byte waits in the input register, then the scan logic turns it into
// zero to three results in the result register, which sends one result a cycle
// a new byte can be taken every cycle while each byte makes at most one result and
// out_stall is low; a byte making more results stalls the input until all are sent
// reset puts the scanner in text mode with no part open and enables double-byte
// out_stall holds the current result; the input stalls once both registers are full
module markup_command_tokenizer_unit import mct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_script,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] role,
	output logic       part_start,
	output logic       unterminated,
	output logic       run_last,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	// input register
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        valid_s1;

	// scan state and configuration
	scan_state_t scan_q;
	scan_state_t scan_nxt;
	logic        double_byte_enable_q;

	bundle_t     bundle;
	logic        can_load;
	logic        s1_move;
	logic        accept;

	// the byte in the input register moves on when the result register frees up
	assign s1_move  = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1             <= 1'b0;
			scan_q               <= SCAN_RESET;
			double_byte_enable_q <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				scan_q <= scan_nxt;
			end
			if (cfg_we) begin
				double_byte_enable_q <= cfg_wdata;
			end
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_script;
		end
	end

	mct_step u_step (
		.in_byte            (byte_s1),
		.end_of_script      (eos_s1),
		.double_byte_enable (double_byte_enable_q),
		.cur                (scan_q),
		.nxt                (scan_nxt),
		.bundle             (bundle)
	);

	// bytes that make no result (held marker, brackets) never enter the queue
	mct_out_queue u_out_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s1_move),
		.load_bundle  (bundle),
		.can_load     (can_load),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.role         (role),
		.part_start   (part_start),
		.unterminated (unterminated),
		.run_last     (run_last)
	);

endmodule

/* design/mct_step.sv */
// per-byte scan logic: next scan state and up to three results for one byte
module mct_step import mct_pkg::*; (
	input  logic [7:0]  in_byte,
	input  logic        end_of_script,
	input  logic        double_byte_enable,
	input  scan_state_t cur,
	output scan_state_t nxt,
	output bundle_t     bundle
);

	function automatic result_t mk(input logic [7:0] b, input logic [1:0] r,
	                               input logic s, input logic u);
		result_t x;
		x.out_byte     = b;
		x.role         = r;
		x.part_start   = s;
		x.unterminated = u;
		return x;
	endfunction

	always_comb begin
		scan_state_t st;
		logic [CNT_W-1:0] n;
		logic do_name;
		logic do_text;
		logic unterm;
		logic [7:0] held_b;

		st      = cur;
		n       = '0;
		do_name = 1'b0;
		do_text = 1'b0;
		unterm  = 1'b0;
		bundle  = '0;
		held_b  = cur.held_pct ? CH_PERCENT : CH_BACKSLASH;

		case (cur.mode)
			MODE_TEXT: begin
				if (cur.trail) begin
					st.trail = 1'b0;
					bundle.res[n] = mk(in_byte, ROLE_TEXT, 1'b0, 1'b0);
					n = n + 1'b1;
				end else begin
					do_text = 1'b1;
				end
			end
			MODE_HELD: begin
				if (is_marker(in_byte)) begin
					// doubled marker reads as two text bytes
					bundle.res[n] = mk(held_b, ROLE_TEXT, !cur.in_text, 1'b0);
					n = n + 1'b1;
					bundle.res[n] = mk(in_byte, ROLE_TEXT, 1'b0, 1'b0);
					n = n + 1'b1;
					st.in_text = 1'b1;
					st.mode    = MODE_TEXT;
				end else begin
					bundle.res[n] = mk(held_b, ROLE_NAME, 1'b1, 1'b0);
					n = n + 1'b1;
					st.in_text = 1'b0;
					do_name    = 1'b1;
				end
			end
			MODE_NAME: begin
				do_name = 1'b1;
			end
			MODE_OPTION: begin
				if (cur.trail) begin
					st.trail = 1'b0;
					bundle.res[n] = mk(in_byte, ROLE_OPTION, 1'b0, 1'b0);
					n = n + 1'b1;
				end else if (cur.esc && (in_byte == CH_RBRACKET)) begin
					st.esc = 1'b0;
					bundle.res[n] = mk(in_byte, ROLE_OPTION, 1'b0, 1'b0);
					n = n + 1'b1;
				end else begin
					st.esc = 1'b0;
					if (in_byte == CH_RBRACKET) begin
						st.mode = MODE_TEXT;
					end else begin
						bundle.res[n] = mk(in_byte, ROLE_OPTION, 1'b0, 1'b0);
						n = n + 1'b1;
						if (in_byte == CH_BACKSLASH) begin
							st.esc = 1'b1;
						end else if (is_lead(in_byte, double_byte_enable)) begin
							st.trail = 1'b1;
						end
					end
				end
			end
			default: begin
				st = cur;
			end
		endcase

		if (do_name) begin
			if (is_name_char(in_byte)) begin
				st.mode = MODE_NAME;
				bundle.res[n] = mk(in_byte, ROLE_NAME, 1'b0, 1'b0);
				n = n + 1'b1;
			end else if (in_byte == CH_LBRACKET) begin
				st.mode  = MODE_OPTION;
				st.esc   = 1'b0;
				st.trail = 1'b0;
			end else begin
				do_text = 1'b1;
			end
		end

		if (do_text) begin
			if (is_marker(in_byte)) begin
				st.mode     = MODE_HELD;
				st.held_pct = (in_byte == CH_PERCENT);
			end else begin
				st.mode = MODE_TEXT;
				bundle.res[n] = mk(in_byte, ROLE_TEXT, !st.in_text, 1'b0);
				n = n + 1'b1;
				st.in_text = 1'b1;
				if (is_lead(in_byte, double_byte_enable)) begin
					st.trail = 1'b1;
				end
			end
		end

		if (end_of_script) begin
			unterm = (st.mode == MODE_OPTION);
			if (st.mode == MODE_HELD) begin
				// lone marker at the end becomes an empty command
				bundle.res[n] = mk(st.held_pct ? CH_PERCENT : CH_BACKSLASH,
				                   ROLE_NAME, 1'b1, 1'b0);
				n = n + 1'b1;
			end
			bundle.res[n] = mk(8'h00, ROLE_END, 1'b0, unterm);
			n = n + 1'b1;
			st = SCAN_RESET;
		end

		bundle.count = n;
		nxt          = st;
	end

endmodule

/* design/mct_out_queue.sv */
// result register for one byte's results, sending one per cycle unless stalled
module mct_out_queue import mct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    load_bundle,
	output logic       can_load,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] role,
	output logic       part_start,
	output logic       unterminated,
	output logic       run_last
);

	bundle_t          bundle_s2;
	logic             valid_s2;
	logic [CNT_W-1:0] idx_q;
	logic             done;
	result_t          cur;

	assign cur          = bundle_s2.res[idx_q];
	assign run_last     = (idx_q == (bundle_s2.count - 1'b1));
	assign done         = valid_s2 && !out_stall && run_last;
	assign can_load     = !valid_s2 || done;
	assign out_valid    = valid_s2;
	assign out_byte     = cur.out_byte;
	assign role         = cur.role;
	assign part_start   = cur.part_start;
	assign unterminated = cur.unterminated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (can_load) begin
			valid_s2 <= load && (load_bundle.count != '0);
			idx_q    <= '0;
		end else if (valid_s2 && !out_stall) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			bundle_s2 <= load_bundle;
		end
	end

endmodule

/* tb/tb_markup_command_tokenizer_unit.sv */
// self-checking testbench for the markup command tokenizer unit
`timescale 1ns / 100ps

module tb_markup_command_tokenizer_unit;
	import mct_pkg::*;

	// one script byte waiting to be offered on the request channel
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} script_item_t;

	// one tagged byte as the unit should hand it out
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] role;
		logic       part_start;
		logic       unterminated;
		logic       run_last;
	} token_t;

	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int PHASE_BYTES   = 27;

	// clock, reset and driven inputs, all at known values from time zero
	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte       = 8'h00;
	logic       end_of_script = 1'b0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] role;
	logic       part_start;
	logic       unterminated;
	logic       run_last;
	logic       cfg_we        = 1'b0;
	logic       cfg_wdata     = 1'b0;

	// stimulus and expectation stores
	script_item_t script_bytes[$];
	token_t       expected_tokens[$];
	logic [7:0]   draft[$];
	token_t       burst[$];

	// idling knobs, changed by the sequence only on falling edges
	int unsigned send_idle_pct  = 21;
	int unsigned recv_stall_pct = 69;
	bit          hold_sender    = 1'b0;

	// bookkeeping
	int mismatches    = 0;
	int queued_bytes  = 0;
	int bytes_sent    = 0;
	int scripts_sent  = 0;
	int tokens_seen   = 0;
	int role_seen[4]  = '{0, 0, 0, 0};
	int open_options  = 0;

	// predicted scanner state and our copy of the double-byte register
	mode_t scan_mode_q = MODE_TEXT;
	logic  held_pct_q  = 1'b0;
	logic  want_trail  = 1'b0;
	logic  opt_esc_q   = 1'b0;
	logic  text_open_q = 1'b0;
	logic  dbl_en_q    = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	markup_command_tokenizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_script(end_of_script),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.role         (role),
		.part_start   (part_start),
		.unterminated (unterminated),
		.run_last     (run_last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// token prediction
	// ------------------------------------------------------------------

	function automatic bit opens_command(input logic [7:0] b);
		return b inside {CH_BACKSLASH, CH_PERCENT};
	endfunction

	// shift-jis first byte, only while double-byte handling is on
	function automatic bit starts_wide_char(input logic [7:0] b);
		return dbl_en_q && (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
	endfunction

	// letters, digits and the five punctuation marks allowed in a name
	function automatic bit fits_name(input logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			CH_BANG, CH_STAR, CH_AMP, CH_QUEST, CH_UNDER};
	endfunction

	function automatic logic [7:0] held_char();
		return held_pct_q ? CH_PERCENT : CH_BACKSLASH;
	endfunction

	task automatic add_token(input logic [7:0] b, input logic [1:0] r,
			input logic st, input logic un);
		token_t t;
		t.out_byte     = b;
		t.role         = r;
		t.part_start   = st;
		t.unterminated = un;
		t.run_last     = 1'b0;
		burst = {burst, t};
	endtask

	// byte seen with no command in progress
	task automatic plain_byte(input logic [7:0] b);
		if (opens_command(b)) begin
			scan_mode_q = MODE_HELD;
			held_pct_q  = (b == CH_PERCENT);
		end else begin
			scan_mode_q = MODE_TEXT;
			add_token(b, ROLE_TEXT, !text_open_q, 1'b0);
			text_open_q = 1'b1;
			if (starts_wide_char(b))
				want_trail = 1'b1;
		end
	endtask

	// byte right after a marker or inside a name
	task automatic name_or_plain(input logic [7:0] b);
		if (fits_name(b)) begin
			scan_mode_q = MODE_NAME;
			add_token(b, ROLE_NAME, 1'b0, 1'b0);
		end else if (b == CH_LBRACKET) begin
			scan_mode_q = MODE_OPTION;
			opt_esc_q   = 1'b0;
			want_trail  = 1'b0;
		end else begin
			plain_byte(b);
		end
	endtask

	// expected tokens for one accepted script byte, appended in order
	task automatic tokenize_byte(input logic [7:0] b, input logic eos);
		token_t t;
		logic   unt;
		burst.delete();
		case (scan_mode_q)
			MODE_TEXT: begin
				if (want_trail) begin
					want_trail = 1'b0;
					add_token(b, ROLE_TEXT, 1'b0, 1'b0);
				end else begin
					plain_byte(b);
				end
			end
			MODE_HELD: begin
				if (opens_command(b)) begin
					// doubled marker is literal text
					add_token(held_char(), ROLE_TEXT, !text_open_q, 1'b0);
					add_token(b, ROLE_TEXT, 1'b0, 1'b0);
					text_open_q = 1'b1;
					scan_mode_q = MODE_TEXT;
				end else begin
					add_token(held_char(), ROLE_NAME, 1'b1, 1'b0);
					text_open_q = 1'b0;
					name_or_plain(b);
				end
			end
			MODE_NAME: begin
				name_or_plain(b);
			end
			default: begin
				if (want_trail) begin
					want_trail = 1'b0;
					add_token(b, ROLE_OPTION, 1'b0, 1'b0);
				end else if (opt_esc_q && b == CH_RBRACKET) begin
					// escaped bracket stays in the option
					opt_esc_q = 1'b0;
					add_token(b, ROLE_OPTION, 1'b0, 1'b0);
				end else begin
					opt_esc_q = 1'b0;
					if (b == CH_RBRACKET) begin
						scan_mode_q = MODE_TEXT;
					end else begin
						add_token(b, ROLE_OPTION, 1'b0, 1'b0);
						if (b == CH_BACKSLASH)
							opt_esc_q = 1'b1;
						else if (starts_wide_char(b))
							want_trail = 1'b1;
					end
				end
			end
		endcase
		if (eos) begin
			unt = (scan_mode_q == MODE_OPTION);
			// a marker still held at the end becomes an empty command
			if (scan_mode_q == MODE_HELD)
				add_token(held_char(), ROLE_NAME, 1'b1, 1'b0);
			add_token(8'h00, ROLE_END, 1'b0, unt);
			scan_mode_q = MODE_TEXT;
			held_pct_q  = 1'b0;
			want_trail  = 1'b0;
			opt_esc_q   = 1'b0;
			text_open_q = 1'b0;
		end
		foreach (burst[i]) begin
			t          = burst[i];
			t.run_last = (i == burst.size() - 1);
			expected_tokens = {expected_tokens, t};
		end
	endtask

	// ------------------------------------------------------------------
	// request side: offers queued script bytes, predicts on acceptance
	// ------------------------------------------------------------------

	always @(posedge clk) begin : driver
		script_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				tokenize_byte(in_byte, end_of_script);
				bytes_sent++;
				if (end_of_script)
					scripts_sent++;
			end
			// a stalled request keeps its payload
			if (!in_valid || !in_stall) begin
				if (!hold_sender && script_bytes.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					nxt = script_bytes.pop_front();
					in_valid      <= 1'b1;
					in_byte       <= nxt.value;
					end_of_script <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: random stall, field-by-field comparison
	// ------------------------------------------------------------------

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			role_seen[role]++;
			if (role == ROLE_END && unterminated)
				open_options++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, expected none got byte %h role %0d",
					$time, out_byte, role);
			end else begin
				want = expected_tokens.pop_front();
				check_field("out_byte", want.out_byte, out_byte);
				check_field("role", 8'(want.role), 8'(role));
				check_field("part_start", 8'(want.part_start), 8'(part_start));
				check_field("unterminated", 8'(want.unterminated), 8'(unterminated));
				check_field("run_last", 8'(want.run_last), 8'(run_last));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// script building
	// ------------------------------------------------------------------

	// appends one byte to the script being drafted
	task automatic put_draft(input logic [7:0] b);
		draft = {draft, b};
	endtask

	// moves the draft into the request queue, flagging its final byte
	task automatic flush_draft();
		script_item_t it;
		foreach (draft[i]) begin
			it.value = draft[i];
			it.last  = (i == draft.size() - 1);
			script_bytes = {script_bytes, it};
		end
		queued_bytes += draft.size();
		draft.delete();
	endtask

	function automatic logic [7:0] pick_marker();
		return $urandom_range(1) ? CH_BACKSLASH : CH_PERCENT;
	endfunction

	function automatic logic [7:0] pick_lead();
		return $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
			: 8'($urandom_range(8'hFC, 8'hE0));
	endfunction

	function automatic logic [7:0] pick_name_char();
		string pool;
		pool = "AZaz09!*&?_Qm5";
		return pool[$urandom_range(pool.len() - 1)];
	endfunction

	// option body: escaped brackets, wide chars and arbitrary bytes
	task automatic draft_option(input bit closed);
		put_draft(CH_LBRACKET);
		repeat ($urandom_range(4)) begin
			case ($urandom_range(3))
				0: begin
					put_draft(CH_BACKSLASH);
					put_draft(CH_RBRACKET);
				end
				1: begin
					put_draft(pick_lead());
					put_draft(8'($urandom_range(255)));
				end
				default: put_draft(8'($urandom_range(255)));
			endcase
		end
		if (closed)
			put_draft(CH_RBRACKET);
	endtask

	// mostly well-formed script with random content; ragged ones end mid-construct
	task automatic queue_random_script(input bit ragged);
		repeat ($urandom_range(6, 1)) begin
			case ($urandom_range(5))
				0: repeat ($urandom_range(4, 1)) put_draft(8'($urandom_range(126, 32)));
				1: begin
					put_draft(pick_lead());
					put_draft(8'($urandom_range(255)));
				end
				2: begin
					put_draft(pick_marker());
					put_draft(pick_marker());
				end
				3, 4: begin
					put_draft(pick_marker());
					repeat ($urandom_range(4)) put_draft(pick_name_char());
					if ($urandom_range(1))
						draft_option(1'b1);
				end
				default: put_draft(8'($urandom_range(255)));
			endcase
		end
		if (ragged) begin
			case ($urandom_range(2))
				0: put_draft(pick_marker());
				1: begin
					put_draft(pick_marker());
					put_draft(pick_name_char());
					draft_option(1'b0);
				end
				default: put_draft(pick_lead());
			endcase
		end
		flush_draft();
	endtask

	task automatic queue_random_bytes(input int count);
		int goal;
		goal = queued_bytes + count;
		while (queued_bytes < goal)
			queue_random_script($urandom_range(4) == 0);
	endtask

	// ------------------------------------------------------------------
	// sequencing helpers
	// ------------------------------------------------------------------

	// no request pending and every expected token seen, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		while (script_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_double_byte(input logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		dbl_en_q = v;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero and all-ones bytes, doubled markers, every name
		// punctuation mark, escaped bracket and wide char inside an option,
		// raw trail byte in text, empty name with option, held marker at end
		draft = '{8'h00, 8'hFF, CH_BACKSLASH, CH_PERCENT, CH_PERCENT, CH_BANG,
			CH_STAR, CH_AMP, CH_QUEST, CH_UNDER, CH_LBRACKET, CH_BACKSLASH,
			CH_RBRACKET, 8'h81, CH_RBRACKET, CH_RBRACKET, 8'h9F, CH_BACKSLASH,
			CH_BACKSLASH, CH_LBRACKET, CH_RBRACKET, 8'h5A, CH_BACKSLASH};
		flush_draft();
		// option still open at the end
		draft = '{CH_PERCENT, 8'h61, CH_LBRACKET, 8'h78};
		flush_draft();
		// lead byte as the final byte, its trail never comes
		draft = '{8'hFC};
		flush_draft();
		wait_idle();

		// single-byte mode, sender mostly busy, receiver mostly stalled
		write_double_byte(1'b0);
		queue_random_bytes(2 * PHASE_BYTES);
		wait_idle();

		// double-byte back on, idling the other way round
		write_double_byte(1'b1);
		send_idle_pct  = 69;
		recv_stall_pct = 21;
		queue_random_bytes(2 * PHASE_BYTES);
		// sender holds off mid-phase until the unit has emptied out
		while (script_bytes.size() > PHASE_BYTES)
			@(negedge clk);
		hold_sender = 1'b1;
		while (in_valid || expected_tokens.size() != 0)
			@(negedge clk);
		hold_sender = 1'b0;
		wait_idle();

		// no idling at all, both register values
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_double_byte(1'b0);
		queue_random_bytes(PHASE_BYTES);
		wait_idle();
		write_double_byte(1'b1);
		queue_random_bytes(PHASE_BYTES);
		wait_idle();

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d bytes in %0d scripts, %0d results checked", bytes_sent,
			scripts_sent, tokens_seen);
		$display("results by role: text %0d, name %0d, option %0d, end %0d (%0d open options)",
			role_seen[0], role_seen[1], role_seen[2], role_seen[3], open_options);
		if (mismatches == 0)
			$display("tb_markup_command_tokenizer_unit: clean");
		else
			$display("tb_markup_command_tokenizer_unit: errors");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d results still expected", expected_tokens.size());
		$display("tb_markup_command_tokenizer_unit: errors");
		$finish;
	end

endmodule

/* markup_command_tokenizer_unit.f */
design/mct_pkg.sv
design/mct_step.sv
design/mct_out_queue.sv
design/markup_command_tokenizer_unit.sv
tb/tb_markup_command_tokenizer_unit.sv
